>>> hdl/mrtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, constants and CRC helper for the Modbus RTU master framer.
// ----------------------------------------------------------------------------
package mrtu_pkg;

	localparam int MAX_REGS_DEF  = 125;
	localparam int MIN_FRAME_DEF = 4;
	localparam int MAX_FRAME_DEF = 256;

	typedef enum logic [1:0] {
		REQ_HEADER = 2'd0,
		REQ_DATA   = 2'd1,
		REQ_REPLY  = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_REJECT = 2'd2
	} out_kind_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_EXC = 2'd1,
		ST_ERR = 2'd2
	} reply_status_t;

	typedef enum logic [1:0] {
		PK_IDLE  = 2'd0,
		PK_DATA  = 2'd1,
		PK_REPLY = 2'd2
	} pend_t;

	localparam logic [7:0] FC_READ   = 8'h03;
	localparam logic [7:0] FC_WRITE1 = 8'h06;
	localparam logic [7:0] FC_WRITEN = 8'h10;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  slave_addr;
		logic [7:0]  func_code;
		logic [15:0] start_reg;
		logic [6:0]  reg_count;
		logic [15:0] data_word;
		logic [7:0]  rx_byte;
		logic        rx_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic [7:0] reply_len;
		logic [7:0] timeout_ms;
		logic       no_reply;
		logic [1:0] reply_status;
		logic [7:0] reply_func;
	} out_item_t;

	// Job codes carried in the queue from front to back
	typedef enum logic [1:0] {
		JOB_BYTE   = 2'd0,
		JOB_FINISH = 2'd1,
		JOB_RESULT = 2'd2
	} job_op_t;

	// One queue entry: plain byte, CRC trailer request or finished result
	typedef struct packed {
		job_op_t    op;
		logic       restart;
		logic [7:0] data;
		logic [7:0] reply_len;
		logic       no_reply;
		out_item_t  res;
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hdl/mrtu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_front
// Accepts items, tracks request state, checks replies and emits job entries.
// A header yields up to seven byte jobs and a finish job, one per ready cycle.
// ----------------------------------------------------------------------------
module mrtu_front import mrtu_pkg::*; #(
	parameter int MAX_REGS  = MAX_REGS_DEF,
	parameter int MIN_FRAME = MIN_FRAME_DEF,
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          job_valid,
	input  wire logic     job_ready,
	output job_t          job
);

	// header expansion buffer
	logic [2:0]  hb_cnt_q;       // bytes remaining in expansion
	logic [2:0]  hb_idx_q;
	logic [7:0]  hb_byte_q [7];
	logic        hb_fin_q;
	logic        hb_restart_q;
	logic [1:0]  dw_left_q;
	logic [7:0]  dw_lo_q;
	logic        dw_fin_q;

	pend_t       pend_q;
	logic [6:0]  words_left_q;
	logic [7:0]  exp_len_q;
	logic        bcast_q;
	logic [15:0] rx_crc_q;
	logic [8:0]  rx_cnt_q;
	logic [7:0]  cap_func_q;

	logic busy;
	assign busy = (hb_cnt_q != 3'd0) || hb_fin_q || (dw_left_q != 2'd0) || dw_fin_q;
	assign in_ready = !busy && job_ready;

	logic acc;
	assign acc = in_valid && in_ready;

	logic fc_ok, hdr_ok;
	assign fc_ok  = (in_data.func_code == FC_READ) || (in_data.func_code == FC_WRITE1)
		|| (in_data.func_code == FC_WRITEN);
	assign hdr_ok = fc_ok && ({25'd0, in_data.reg_count} <= MAX_REGS);

	logic [15:0] rx_crc_n;
	logic [8:0]  rx_cnt_n;
	logic        rx_full, rx_done, crc_ok;
	assign rx_crc_n = crc_byte(rx_crc_q, in_data.rx_byte);
	assign rx_cnt_n = (rx_cnt_q == 9'h1FF) ? rx_cnt_q : rx_cnt_q + 9'd1;
	assign rx_full  = rx_cnt_n >= {1'b0, exp_len_q};
	assign rx_done  = rx_full || in_data.rx_end;
	assign crc_ok   = (rx_crc_n == 16'd0) && ({23'd0, rx_cnt_n} >= MIN_FRAME)
		&& ({23'd0, rx_cnt_n} <= MAX_FRAME);

	// job output
	always_comb begin
		job = '0;
		job_valid = 1'b0;
		if (hb_cnt_q != 3'd0) begin
			job_valid = 1'b1;
			job.op = JOB_BYTE;
			job.data = hb_byte_q[hb_idx_q];
			job.restart = hb_restart_q && (hb_idx_q == 3'd0);
		end else if (hb_fin_q || dw_fin_q) begin
			job_valid = 1'b1;
			job.op = JOB_FINISH;
			job.reply_len = bcast_q ? 8'd0 : exp_len_q;
			job.no_reply = bcast_q;
		end else if (dw_left_q != 2'd0) begin
			job_valid = 1'b1;
			job.op = JOB_BYTE;
			job.data = dw_lo_q;
		end else if (acc) begin
			priority case (in_data.req_type)
				REQ_HEADER: begin
					if (!hdr_ok) begin
						job_valid = 1'b1;
						job.op = JOB_RESULT;
						job.res.out_kind = KIND_REJECT;
					end
				end
				REQ_DATA: begin
					if (pend_q == PK_DATA) begin
						job_valid = 1'b1;
						job.op = JOB_BYTE;
						job.data = in_data.data_word[15:8];
					end
				end
				REQ_REPLY: begin
					if (pend_q == PK_REPLY && rx_done) begin
						job_valid = 1'b1;
						job.op = JOB_RESULT;
						job.res.out_kind = KIND_STATUS;
						if (!crc_ok) begin
							job.res.reply_status = ST_ERR;
						end else if (rx_full) begin
							job.res.reply_status = ST_OK;
						end else begin
							job.res.reply_status = ST_EXC;
							job.res.reply_func = (rx_cnt_q == 9'd1) ? in_data.rx_byte
								: cap_func_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_cnt_q     <= '0;
			hb_idx_q     <= '0;
			hb_fin_q     <= 1'b0;
			hb_restart_q <= 1'b0;
			dw_left_q    <= '0;
			dw_fin_q     <= 1'b0;
			pend_q       <= PK_IDLE;
			words_left_q <= '0;
			exp_len_q    <= '0;
			bcast_q      <= 1'b0;
			rx_crc_q     <= 16'hFFFF;
			rx_cnt_q     <= '0;
			cap_func_q   <= '0;
		end else begin
			if (hb_cnt_q != 3'd0) begin
				if (job_ready) begin
					hb_cnt_q <= hb_cnt_q - 3'd1;
					hb_idx_q <= hb_idx_q + 3'd1;
				end
			end else if (hb_fin_q || dw_fin_q) begin
				if (job_ready) begin
					hb_fin_q <= 1'b0;
					dw_fin_q <= 1'b0;
					pend_q   <= bcast_q ? PK_IDLE : PK_REPLY;
					rx_cnt_q <= '0;
					rx_crc_q <= 16'hFFFF;
					cap_func_q <= '0;
				end
			end else if (dw_left_q != 2'd0) begin
				if (job_ready) begin
					dw_left_q <= 2'd0;
					dw_fin_q  <= (words_left_q == 7'd0);
				end
			end else if (acc) begin
				priority case (in_data.req_type)
					REQ_HEADER: begin
						if (!hdr_ok) begin
							pend_q       <= PK_IDLE;
							words_left_q <= '0;
						end else begin
							bcast_q <= (in_data.slave_addr == 8'd0);
							exp_len_q <= (in_data.func_code != FC_READ) ? 8'd8
								: (in_data.reg_count > 7'd1)
								? 8'd5 + {in_data.reg_count, 1'b0} : 8'd7;
							hb_restart_q <= 1'b1;
							hb_idx_q <= '0;
							hb_byte_q[0] <= in_data.slave_addr;
							hb_byte_q[1] <= in_data.func_code;
							hb_byte_q[2] <= in_data.start_reg[15:8];
							hb_byte_q[3] <= in_data.start_reg[7:0];
							hb_byte_q[4] <= 8'd0;
							hb_byte_q[5] <= {1'b0, in_data.reg_count};
							hb_byte_q[6] <= {in_data.reg_count, 1'b0};
							if (in_data.func_code == FC_READ) begin
								hb_cnt_q <= 3'd6;
								hb_fin_q <= 1'b1;
								pend_q       <= PK_IDLE;
								words_left_q <= '0;
							end else if (in_data.func_code == FC_WRITE1) begin
								hb_cnt_q <= 3'd4;
								words_left_q <= 7'd1;
								pend_q <= PK_DATA;
							end else begin
								hb_cnt_q <= 3'd7;
								if (in_data.reg_count == 7'd0) begin
									hb_fin_q <= 1'b1;
									pend_q       <= PK_IDLE;
									words_left_q <= '0;
								end else begin
									words_left_q <= in_data.reg_count;
									pend_q <= PK_DATA;
								end
							end
						end
					end
					REQ_DATA: begin
						if (pend_q == PK_DATA) begin
							dw_left_q <= 2'd1;
							dw_lo_q <= in_data.data_word[7:0];
							words_left_q <= words_left_q - 7'd1;
							if (words_left_q == 7'd1) begin
								pend_q <= PK_IDLE;
							end
						end
					end
					REQ_REPLY: begin
						if (pend_q == PK_REPLY) begin
							if (rx_cnt_q == 9'd1) begin
								cap_func_q <= in_data.rx_byte;
							end
							rx_crc_q <= rx_crc_n;
							rx_cnt_q <= rx_cnt_n;
							if (rx_done) begin
								pend_q <= PK_IDLE;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/mrtu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_queue
// Small FIFO of job entries between the front and back parts.
// ----------------------------------------------------------------------------
module mrtu_queue import mrtu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire job_t wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output job_t      rd_data
);
	localparam int AW = $clog2(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	logic do_wr, do_rd;
	assign wr_ready = cnt_q != DEPTH[AW:0];
	assign rd_valid = cnt_q != '0;
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {{AW{1'b0}}, do_wr} - {{AW{1'b0}}, do_rd};
		end
	end
endmodule
`default_nettype wire

>>> hdl/mrtu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_back
// Runs the transmit CRC and frame length, appends the CRC trailer and
// computes the reply timeout. One result leaves per cycle unless stalled.
// ----------------------------------------------------------------------------
module mrtu_back import mrtu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic      job_ready,
	input  wire job_t job,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data
);
	logic [15:0] crc_q;
	logic [8:0]  flen_q;
	logic        hi_pend_q;     // second trailer byte still to send
	logic [7:0]  hi_len_q;
	logic        hi_nr_q;
	logic [7:0]  tmo_q;
	logic        ov_q;
	out_item_t   od_q;

	logic [15:0] crc_n;
	logic [8:0]  flen_n;
	logic        hi_pend_n;
	logic [7:0]  hi_len_n;
	logic        hi_nr_n;
	logic [7:0]  tmo_n;
	logic        ov_n;
	out_item_t   od_n;

	logic        can_load;
	logic [15:0] crc_base;
	logic [8:0]  flen_base;
	logic [8:0]  flen_fin;
	logic [9:0]  tmo_x;
	logic [29:0] tmo_prod;

	assign can_load  = !ov_q || out_ready;
	assign job_ready = can_load && !hi_pend_q;
	assign crc_base  = job.restart ? 16'hFFFF : crc_q;
	assign flen_base = job.restart ? 9'd0 : flen_q;
	assign flen_fin  = flen_q + 9'd2;
	// x*578/1000 as x*ceil(0.578*2^20) >> 20, exact for every 10-bit x
	assign tmo_x     = {1'b0, flen_fin} + 10'd1;
	assign tmo_prod  = {20'd0, tmo_x} * 30'd606077;

	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_comb begin
		crc_n     = crc_q;
		flen_n    = flen_q;
		hi_pend_n = hi_pend_q;
		hi_len_n  = hi_len_q;
		hi_nr_n   = hi_nr_q;
		tmo_n     = tmo_q;
		ov_n      = ov_q;
		od_n      = od_q;
		if (can_load) begin
			ov_n = 1'b0;
			if (hi_pend_q) begin
				ov_n = 1'b1;
				hi_pend_n = 1'b0;
				od_n = '0;
				od_n.out_kind   = KIND_TX;
				od_n.tx_byte    = crc_q[15:8];
				od_n.tx_last    = 1'b1;
				od_n.reply_len  = hi_len_q;
				od_n.no_reply   = hi_nr_q;
				od_n.timeout_ms = tmo_q;
			end else if (job_valid) begin
				ov_n = 1'b1;
				od_n = '0;
				unique case (job.op)
					JOB_BYTE: begin
						crc_n  = crc_byte(crc_base, job.data);
						flen_n = flen_base + 9'd1;
						od_n.tx_byte = job.data;
					end
					JOB_FINISH: begin
						flen_n    = flen_fin;
						hi_pend_n = 1'b1;
						hi_len_n  = job.reply_len;
						hi_nr_n   = job.no_reply;
						tmo_n     = tmo_prod[27:20] + 8'd20;
						od_n.tx_byte = crc_q[7:0];
					end
					JOB_RESULT: begin
						od_n = job.res;
					end
					default: ov_n = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= 16'hFFFF;
			flen_q    <= '0;
			hi_pend_q <= 1'b0;
			hi_len_q  <= '0;
			hi_nr_q   <= 1'b0;
			tmo_q     <= '0;
			ov_q      <= 1'b0;
			od_q      <= '0;
		end else begin
			crc_q     <= crc_n;
			flen_q    <= flen_n;
			hi_pend_q <= hi_pend_n;
			hi_len_q  <= hi_len_n;
			hi_nr_q   <= hi_nr_n;
			tmo_q     <= tmo_n;
			ov_q      <= ov_n;
			od_q      <= od_n;
		end
	end
endmodule
`default_nettype wire

>>> hdl/modbus_rtu_master_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer
// Modbus RTU master frame builder and reply checker.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries request headers, write
// data words and reply bytes. Output channel (out_valid/out_ready/out_data)
// carries transmit bytes, reply status and reject results.
// A header is expanded by the front part at one job per cycle while the
// queue accepts, and in_ready stays low until the expansion is done. A data
// word holds in_ready low until its low byte job, and the finish job when it
// closes the frame, have been passed on. Reply bytes and stray items are
// taken every cycle while no expansion is under way and the queue has room.
// The back part sends one byte per cycle while the receiver is ready; the
// CRC trailer goes out as two output items. Jobs pass through the job queue
// and output register; a header's bytes pass the expansion buffer first.
// A four-entry job queue between the parts lets the front keep accepting
// while the receiver stalls; once it fills, in_ready drops.
// Reset clears all request state: CRCs to 0xFFFF, counts to zero, idle.
// ----------------------------------------------------------------------------
module modbus_rtu_master_framer import mrtu_pkg::*; #(
	parameter int MAX_REGS  = MAX_REGS_DEF,
	parameter int MIN_FRAME = MIN_FRAME_DEF,
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, b_job;

	mrtu_front #(
		.MAX_REGS (MAX_REGS),
		.MIN_FRAME(MIN_FRAME),
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	mrtu_queue #(.DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
	);

	mrtu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

>>> hdl/mrtu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_props
// Port-level checks for the framer, bound to the top level.
// ----------------------------------------------------------------------------
module mrtu_props import mrtu_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.out_kind <= KIND_REJECT)
		else $error("bad out_kind");

	a_last_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_last |-> out_data.out_kind == KIND_TX)
		else $error("tx_last outside transmit item");

	a_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_last |-> out_data.timeout_ms >= 8'd20)
		else $error("timeout below floor");

	a_nr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_reply |-> out_data.reply_len == 8'd0)
		else $error("broadcast with reply length");
endmodule

bind modbus_rtu_master_framer mrtu_props u_chk (.*);
`default_nettype wire

>>> tb/mrtu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_checker
// Watches both channels of the Modbus RTU master framer, predicts the
// transmit bytes, reply status and rejects for every accepted item, and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module mrtu_checker import mrtu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_item_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_item_t out_data,
	output int             fail_count,
	output int             pending_count
);

	out_item_t  frame_q[$];
	logic [15:0] tx_crc, rx_crc;
	logic [8:0]  rx_count, frame_len;
	logic [7:0]  exp_len, cap_func;
	logic [6:0]  words_left;
	pend_t       pend;
	logic        bcast;

	assign pending_count = frame_q.size();

	function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ 16'hA001;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	task automatic push_result(out_kind_t k, logic [7:0] b, logic last, logic [7:0] rl,
			logic [7:0] tmo, logic nr, reply_status_t st, logic [7:0] fn);
		out_item_t o;
		o = '0;
		o.out_kind = k;
		o.tx_byte = b;
		o.tx_last = last;
		o.reply_len = rl;
		o.timeout_ms = tmo;
		o.no_reply = nr;
		o.reply_status = st;
		o.reply_func = fn;
		frame_q.push_back(o);
	endtask

	task automatic send_byte(logic [7:0] b);
		tx_crc = crc_step(tx_crc, b);
		frame_len = frame_len + 9'd1;
		push_result(KIND_TX, b, 1'b0, 8'd0, 8'd0, 1'b0, ST_OK, 8'd0);
	endtask

	task automatic close_frame();
		int tmo;
		push_result(KIND_TX, tx_crc[7:0], 1'b0, 8'd0, 8'd0, 1'b0, ST_OK, 8'd0);
		frame_len = frame_len + 9'd2;
		tmo = ((int'(frame_len) + 1) * 578) / 1000 + 20;
		push_result(KIND_TX, tx_crc[15:8], 1'b1, bcast ? 8'd0 : exp_len, tmo[7:0],
			bcast, ST_OK, 8'd0);
		rx_count = '0;
		rx_crc = 16'hFFFF;
		cap_func = '0;
		words_left = '0;
		pend = bcast ? PK_IDLE : PK_REPLY;
	endtask

	task automatic predict_item(in_item_t it);
		logic full, crc_ok;
		reply_status_t st;
		logic [7:0] fn;
		case (req_type_t'(it.req_type))
			REQ_HEADER: begin
				pend = PK_IDLE;
				words_left = '0;
				if ((it.func_code != FC_READ && it.func_code != FC_WRITE1 &&
						it.func_code != FC_WRITEN) || it.reg_count > MAX_REGS_DEF) begin
					push_result(KIND_REJECT, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, ST_OK, 8'd0);
				end else begin
					bcast = (it.slave_addr == 8'd0);
					tx_crc = 16'hFFFF;
					frame_len = '0;
					if (it.func_code == FC_READ)
						exp_len = (it.reg_count > 1) ? 8'd5 + 8'(2 * it.reg_count) : 8'd7;
					else
						exp_len = 8'd8;
					send_byte(it.slave_addr);
					send_byte(it.func_code);
					send_byte(it.start_reg[15:8]);
					send_byte(it.start_reg[7:0]);
					if (it.func_code == FC_READ) begin
						send_byte(8'd0);
						send_byte({1'b0, it.reg_count});
						close_frame();
					end else if (it.func_code == FC_WRITE1) begin
						words_left = 7'd1;
						pend = PK_DATA;
					end else begin
						send_byte(8'd0);
						send_byte({1'b0, it.reg_count});
						send_byte(8'(2 * it.reg_count));
						if (it.reg_count == 0) begin
							close_frame();
						end else begin
							words_left = it.reg_count;
							pend = PK_DATA;
						end
					end
				end
			end
			REQ_DATA: begin
				if (pend == PK_DATA) begin
					send_byte(it.data_word[15:8]);
					send_byte(it.data_word[7:0]);
					words_left = words_left - 7'd1;
					if (words_left == 0)
						close_frame();
				end
			end
			REQ_REPLY: begin
				if (pend == PK_REPLY) begin
					if (rx_count == 9'd1)
						cap_func = it.rx_byte;
					rx_crc = crc_step(rx_crc, it.rx_byte);
					if (rx_count < 9'h1FF)
						rx_count = rx_count + 9'd1;
					full = (rx_count >= {1'b0, exp_len});
					if (full || it.rx_end) begin
						crc_ok = (rx_crc == 0) && rx_count >= MIN_FRAME_DEF &&
							rx_count <= MAX_FRAME_DEF;
						fn = 8'd0;
						if (!crc_ok) begin
							st = ST_ERR;
						end else if (full) begin
							st = ST_OK;
						end else begin
							st = ST_EXC;
							fn = cap_func;
						end
						push_result(KIND_STATUS, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, st, fn);
						pend = PK_IDLE;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		tx_crc = 16'hFFFF;
		rx_crc = 16'hFFFF;
		rx_count = '0;
		frame_len = '0;
		exp_len = '0;
		cap_func = '0;
		words_left = '0;
		pend = PK_IDLE;
		bcast = 1'b0;
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (frame_q.size() == 0) begin
					report_mismatch("unexpected item", int'(out_data.tx_byte), 0);
				end else begin
					e = frame_q.pop_front();
					if (out_data.out_kind !== e.out_kind)
						report_mismatch("out_kind", out_data.out_kind, e.out_kind);
					if (out_data.tx_byte !== e.tx_byte)
						report_mismatch("tx_byte", out_data.tx_byte, e.tx_byte);
					if (out_data.tx_last !== e.tx_last)
						report_mismatch("tx_last", out_data.tx_last, e.tx_last);
					if (out_data.reply_len !== e.reply_len)
						report_mismatch("reply_len", out_data.reply_len, e.reply_len);
					if (out_data.timeout_ms !== e.timeout_ms)
						report_mismatch("timeout_ms", out_data.timeout_ms, e.timeout_ms);
					if (out_data.no_reply !== e.no_reply)
						report_mismatch("no_reply", out_data.no_reply, e.no_reply);
					if (out_data.reply_status !== e.reply_status)
						report_mismatch("reply_status", out_data.reply_status,
							e.reply_status);
					if (out_data.reply_func !== e.reply_func)
						report_mismatch("reply_func", out_data.reply_func, e.reply_func);
				end
			end
			// predict after popping so a same-edge result is not compared too early
			if (in_valid && in_ready)
				predict_item(in_data);
		end
	end

endmodule

>>> tb/tb_modbus_rtu_master_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_master_framer
// Drives directed and random request, data and reply items into the framer
// with random idling on both sides and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_master_framer;
	import mrtu_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	int        fail_count;
	int        pending_count;
	int        idle_cycles;
	bit        calm;
	bit        hold_off;
	int        sent_items;

	modbus_rtu_master_framer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	mrtu_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Send one item and wait for its handshake, with an optional idle burst first
	task automatic send_item(in_item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	function automatic in_item_t noise_item();
		in_item_t it;
		it = in_item_t'(66'({$urandom, $urandom, $urandom}));
		return it;
	endfunction

	task automatic send_header(logic [7:0] addr, logic [7:0] fc, logic [15:0] sr,
			logic [6:0] rc);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_HEADER;
		it.slave_addr = addr;
		it.func_code = fc;
		it.start_reg = sr;
		it.reg_count = rc;
		send_item(it);
	endtask

	task automatic send_word(logic [15:0] w);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_DATA;
		it.data_word = w;
		send_item(it);
	endtask

	task automatic send_rx(logic [7:0] b, logic last);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_REPLY;
		it.rx_byte = b;
		it.rx_end = last;
		send_item(it);
	endtask

	function automatic logic [15:0] crc_of(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	// Reply of n bytes with a correct CRC trailer; optionally corrupt one byte
	task automatic send_reply(logic [7:0] addr, logic [7:0] fc, int n, bit corrupt,
			bit mark_end);
		logic [15:0] crc;
		logic [7:0]  b;
		int bad;
		crc = 16'hFFFF;
		bad = corrupt ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == n - 2)
				b = crc[7:0];
			else if (i == n - 1)
				b = crc[15:8];
			else if (i == 0)
				b = addr;
			else if (i == 1)
				b = fc;
			else
				b = 8'($urandom);
			if (i < n - 2)
				crc = crc_of(crc, b);
			if (i == bad)
				b = b ^ 8'(1 << $urandom_range(0, 7));
			send_rx(b, mark_end && i == n - 1);
		end
	endtask

	function automatic int reply_size(logic [7:0] fc, logic [6:0] rc);
		if (fc == FC_READ)
			return rc > 1 ? 5 + 2 * rc : 7;
		return 8;
	endfunction

	// Full request with a reply of random shape, none for a broadcast
	task automatic run_request(logic [7:0] fc, logic [6:0] rc, logic [7:0] addr);
		int full, shape;
		send_header(addr, fc, 16'($urandom), rc);
		if (fc == FC_WRITE1)
			send_word(16'($urandom));
		else if (fc == FC_WRITEN)
			for (int i = 0; i < rc; i++)
				send_word(16'($urandom));
		if (addr == 0)
			return;
		full = reply_size(fc, rc);
		shape = $urandom_range(0, 5);
		case (shape)
			0: send_reply(addr, fc | 8'h80, 5, 1'b0, 1'b1);
			1: send_reply(addr, fc, full, 1'b1, 1'b0);
			2: send_reply(addr, fc, $urandom_range(1, full - 1), $urandom_range(0, 1),
				1'b1);
			default: send_reply(addr, fc, full, 1'b0, $urandom_range(0, 1));
		endcase
	endtask

	function automatic logic [7:0] rand_func();
		case ($urandom_range(0, 3))
			0: return FC_READ;
			1: return FC_WRITE1;
			2: return FC_WRITEN;
			default: return 8'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, one long hold-off, none in the calm phase
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		logic [7:0] fc;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		hold_off = 1'b0;
		sent_items = 0;
		idle_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: stray items at idle, every function, extremes, rejects
		send_word(16'hFFFF);
		send_rx(8'hFF, 1'b1);
		it = noise_item();
		it.req_type = REQ_NONE;
		send_item(it);
		run_request(FC_READ, 7'd1, 8'hFF);
		send_header(8'h01, FC_READ, 16'h0000, 7'd125);
		send_reply(8'h01, FC_READ | 8'h80, 5, 1'b0, 1'b1);
		run_request(FC_READ, 7'd0, 8'd0);
		run_request(FC_WRITE1, 7'd127, 8'h11);
		run_request(FC_WRITEN, 7'd0, 8'h22);
		run_request(FC_WRITEN, 7'd2, 8'd0);
		send_header(8'h05, FC_READ, 16'hFFFF, 7'd126);
		send_header(8'h05, 8'h04, 16'h0000, 7'd3);
		send_header(8'h05, FC_WRITEN, 16'h1234, 7'd3);
		send_word(16'h0000);
		send_header(8'h06, FC_READ, 16'h0001, 7'd2);
		send_rx(8'h06, 1'b0);
		send_header(8'h07, FC_READ, 16'h0002, 7'd2);
		send_reply(8'h07, FC_READ, 9, 1'b0, 1'b0);
		send_rx(8'hAA, 1'b1);

		// Pause until every expected result has come
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);

		// Random: mostly well-formed requests, some noise
		for (int n = 0; sent_items < 130; n++) begin
			if (n == 5)
				hold_off = 1'b1;
			if (sent_items > 110)
				calm = 1'b1;
			if ($urandom_range(0, 7) == 0) begin
				send_item(noise_item());
			end else begin
				fc = rand_func();
				run_request(fc, ($urandom_range(0, 9) == 0) ? 7'($urandom_range(5, 12)) :
					7'($urandom_range(0, 4)), ($urandom_range(0, 5) == 0) ? 8'd0 :
					8'($urandom));
			end
		end
		calm = 1'b1;

		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> modbus_rtu_master_framer.f
hdl/mrtu_pkg.sv
hdl/mrtu_front.sv
hdl/mrtu_queue.sv
hdl/mrtu_back.sv
hdl/modbus_rtu_master_framer.sv
hdl/mrtu_checker.sv
tb/mrtu_checker.sv
tb/tb_modbus_rtu_master_framer.sv
